@@ hdl/rgb_to_hsl_hsv_converter_defines.svh @@
// Assertion macros used by the converter's port-level checker, rhsl_monitor.
// No dependencies.
`ifndef RGB_TO_HSL_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSL_HSV_CONVERTER_DEFINES_SVH

// clocked assertion, disabled while reset is high
`define RHSL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define RHSL_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/rhsl_pkg.sv @@
// Shared widths, constants and types of the RGB to HSL/HSV converter.
// No dependencies.
`default_nettype none
package rhsl_pkg;

   localparam int CH_W  = 8;
   localparam int HUE_W = 9;
   localparam int SAT_W = 7;
   localparam int LVL_W = 7;

   localparam int REQ_W = 24;
   localparam int RSP_W = 24;

   // restoring divider: numerator, denominator and quotient widths
   localparam int DIV_NUM_W = 18;
   localparam int DIV_DEN_W = 10;
   localparam int DIV_QUO_W = 9;

   // level: floor(z / 255) as (z * LVL_RECIP) >> LVL_SHIFT, exact for z < 2^15
   localparam int                     LVL_NUM_W   = 15;
   localparam int                     LVL_RECIP_W = 16;
   localparam logic [LVL_RECIP_W-1:0] LVL_RECIP   = 16'd32897;
   localparam int                     LVL_SHIFT   = 23;
   localparam int                     LVL_PROD_W  = 31;

   // pixel front end plus numerator/denominator stage
   localparam int FRONT_STAGES = 2;

   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] mx;
      logic [CH_W-1:0] mn;
      sector_type      sector;
   } front_type;

   typedef struct packed {
      logic [DIV_NUM_W-1:0] hue_num;
      logic [DIV_DEN_W-1:0] hue_den;
      logic [DIV_NUM_W-1:0] sat_num;
      logic [DIV_DEN_W-1:0] sat_den;
      logic [LVL_NUM_W-1:0] lvl_num;
   } ratio_type;

endpackage
`default_nettype wire

@@ hdl/rhsl_divider.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Uses rhsl_pkg for default widths.
`default_nettype none
module rhsl_divider #(
   parameter int NUM_W = rhsl_pkg::DIV_NUM_W,
   parameter int DEN_W = rhsl_pkg::DIV_DEN_W,
   parameter int QUO_W = rhsl_pkg::DIV_QUO_W
) (
   input  logic             clock,
   input  logic [QUO_W-1:0] stage_en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo
);

   localparam int CMP_W = NUM_W + DEN_W + QUO_W;

   logic [NUM_W-1:0] rem_ff  [QUO_W];
   logic [NUM_W-1:0] rem_in  [QUO_W];
   logic [DEN_W-1:0] den_ff  [QUO_W];
   logic [QUO_W-1:0] quo_ff  [QUO_W];
   logic [QUO_W-1:0] quo_in  [QUO_W];
   logic [NUM_W-1:0] rem_src [QUO_W];
   logic [DEN_W-1:0] den_src [QUO_W];
   logic [QUO_W-1:0] quo_src [QUO_W];
   logic [CMP_W-1:0] shifted [QUO_W];

   always_comb begin
      for (int k = 0; k < QUO_W; k++) begin
         if (k == 0) begin
            rem_src[k] = num;
            den_src[k] = den;
            quo_src[k] = '0;
         end else begin
            rem_src[k] = rem_ff[k-1];
            den_src[k] = den_ff[k-1];
            quo_src[k] = quo_ff[k-1];
         end
         shifted[k] = CMP_W'(den_src[k]) << (QUO_W - 1 - k);
         if (CMP_W'(rem_src[k]) >= shifted[k]) begin
            rem_in[k] = NUM_W'(CMP_W'(rem_src[k]) - shifted[k]);
            quo_in[k] = quo_src[k] | (QUO_W'(1) << (QUO_W - 1 - k));
         end else begin
            rem_in[k] = rem_src[k];
            quo_in[k] = quo_src[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QUO_W; k++) begin
         if (stage_en[k]) begin
            rem_ff[k] <= rem_in[k];
            den_ff[k] <= den_src[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   assign quo = quo_ff[QUO_W-1];

endmodule
`default_nettype wire

@@ hdl/rgb_to_hsl_hsv_converter.sv @@
// Top level of the RGB to HSL/HSV converter: front end, pipeline control, dividers.
// Depends on rhsl_pkg and rhsl_divider.
//
// Takes one 8-bit RGB pixel per clock while rsp_tready is high, and returns hue
// in degrees (0..360), saturation and lightness (csr mode 0, HSL) or value
// (mode 1, HSV) in percent, all rounded half up. One stage is for max/min, one
// for the ratio terms, and nine for the hue and saturation restoring dividers,
// one quotient bit per stage. The level divides by a constant, so it is a
// reciprocal multiply in the first divider stage and then rides along. Every
// stage has its own valid bit, so bubbles close up on a stall and a new pixel
// is taken while a result waits if a stage is empty. Write mode only while idle.
`default_nettype none
module rgb_to_hsl_hsv_converter (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_data,    // mode
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [rhsl_pkg::REQ_W-1:0] req_tdata,  // red[7:0], green[15:8], blue[23:16]
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [rhsl_pkg::RSP_W-1:0] rsp_tdata   // hue[8:0], saturation[15:9],
                                                  // level[22:16], zero[23]
);

   import rhsl_pkg::*;

   localparam int STAGES = FRONT_STAGES + DIV_QUO_W;

   logic              mode_ff;
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES:0]   adv;

   front_type front_in;
   front_type front_ff;
   ratio_type ratio_in;
   ratio_type ratio_ff;

   logic [CH_W-1:0]       d;
   logic [CH_W:0]         sum;
   logic [CH_W-1:0]       pos;
   logic [CH_W-1:0]       neg;
   logic [16:0]           base;
   logic [16:0]           hue_n;
   logic [CH_W-1:0]       sat_base;
   logic [DIV_QUO_W-1:0]  hue_q;
   logic [DIV_QUO_W-1:0]  sat_q;
   logic [LVL_PROD_W-1:0] lvl_prod;
   logic [LVL_W-1:0]      lvl_in;
   logic [LVL_W-1:0]      lvl_ff [DIV_QUO_W];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= csr_data;
      end
   end

   // pipeline control
   always_comb begin
      adv[STAGES] = rsp_tready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      for (int k = 0; k < STAGES; k++) begin
         if (!adv[k]) begin
            valid_in[k] = valid_ff[k];
         end else if (k == 0) begin
            valid_in[k] = req_tvalid;
         end else begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = adv[0];

   // stage 0: max, min, sector
   always_comb begin
      front_in.red   = req_tdata[7:0];
      front_in.green = req_tdata[15:8];
      front_in.blue  = req_tdata[23:16];
      front_in.mx    = front_in.red;
      front_in.mn    = front_in.red;
      if (front_in.green > front_in.mx) front_in.mx = front_in.green;
      if (front_in.blue  > front_in.mx) front_in.mx = front_in.blue;
      if (front_in.green < front_in.mn) front_in.mn = front_in.green;
      if (front_in.blue  < front_in.mn) front_in.mn = front_in.blue;
      if (front_in.mx == front_in.red) begin
         front_in.sector = SECT_RED;
      end else if (front_in.mx == front_in.green) begin
         front_in.sector = SECT_GREEN;
      end else begin
         front_in.sector = SECT_BLUE;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         front_ff <= front_in;
      end
   end

   // stage 1: numerators and denominators, rounding folded in as 2n+q over 2q
   always_comb begin
      d   = front_ff.mx - front_ff.mn;
      sum = {1'b0, front_ff.mx} + {1'b0, front_ff.mn};

      unique case (front_ff.sector)
         SECT_RED: begin
            pos  = front_ff.green;
            neg  = front_ff.blue;
            base = (front_ff.green >= front_ff.blue) ? 17'd0 : 17'(d) * 17'd360;
         end
         SECT_GREEN: begin
            pos  = front_ff.blue;
            neg  = front_ff.red;
            base = 17'(d) * 17'd120;
         end
         SECT_BLUE: begin
            pos  = front_ff.red;
            neg  = front_ff.green;
            base = 17'(d) * 17'd240;
         end
         default: begin
            pos  = '0;
            neg  = '0;
            base = '0;
         end
      endcase

      hue_n = base + 17'(pos) * 17'd60 - 17'(neg) * 17'd60;

      if (mode_ff) begin
         sat_base = front_ff.mx;
      end else if (sum < 9'd255) begin
         sat_base = sum[CH_W-1:0];
      end else begin
         sat_base = CH_W'(9'd510 - sum);
      end

      if (d == '0) begin
         ratio_in.hue_num = '0;
         ratio_in.hue_den = DIV_DEN_W'(1);
         ratio_in.sat_num = '0;
         ratio_in.sat_den = DIV_DEN_W'(1);
      end else begin
         ratio_in.hue_num = {hue_n, 1'b0} + DIV_NUM_W'(d);
         ratio_in.hue_den = DIV_DEN_W'({d, 1'b0});
         ratio_in.sat_num = DIV_NUM_W'(d) * DIV_NUM_W'(200) + DIV_NUM_W'(sat_base);
         ratio_in.sat_den = DIV_DEN_W'({sat_base, 1'b0});
      end

      // level numerator halved so that the divisor is 255 in both modes
      if (mode_ff) begin
         ratio_in.lvl_num = LVL_NUM_W'(front_ff.mx) * LVL_NUM_W'(100) + LVL_NUM_W'(127);
      end else begin
         ratio_in.lvl_num = LVL_NUM_W'(sum) * LVL_NUM_W'(50) + LVL_NUM_W'(127);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         ratio_ff <= ratio_in;
      end
   end

   // stages 2 and up: hue and saturation dividers in lockstep
   rhsl_divider #(
      .NUM_W (DIV_NUM_W),
      .DEN_W (DIV_DEN_W),
      .QUO_W (DIV_QUO_W)
   ) u_hue_div (
      .clock    (clock),
      .stage_en (adv[STAGES-1:FRONT_STAGES]),
      .num      (ratio_ff.hue_num),
      .den      (ratio_ff.hue_den),
      .quo      (hue_q)
   );

   rhsl_divider #(
      .NUM_W (DIV_NUM_W),
      .DEN_W (DIV_DEN_W),
      .QUO_W (DIV_QUO_W)
   ) u_sat_div (
      .clock    (clock),
      .stage_en (adv[STAGES-1:FRONT_STAGES]),
      .num      (ratio_ff.sat_num),
      .den      (ratio_ff.sat_den),
      .quo      (sat_q)
   );

   // level: reciprocal multiply, then delayed alongside the dividers
   assign lvl_prod = LVL_PROD_W'(ratio_ff.lvl_num) * LVL_PROD_W'(LVL_RECIP);
   assign lvl_in   = lvl_prod[LVL_SHIFT +: LVL_W];

   always_ff @(posedge clock) begin
      if (adv[FRONT_STAGES]) begin
         lvl_ff[0] <= lvl_in;
      end
      for (int k = 1; k < DIV_QUO_W; k++) begin
         if (adv[FRONT_STAGES + k]) begin
            lvl_ff[k] <= lvl_ff[k-1];
         end
      end
   end

   assign rsp_tvalid = valid_ff[STAGES-1];
   assign rsp_tdata  = {1'b0, lvl_ff[DIV_QUO_W-1], SAT_W'(sat_q), HUE_W'(hue_q)};

endmodule
`default_nettype wire

@@ hdl/rhsl_monitor.sv @@
// Port-level checker for the RGB to HSL/HSV converter, bound to the top level.
// Depends on rhsl_pkg and rgb_to_hsl_hsv_converter_defines.svh.
`default_nettype none
`include "rgb_to_hsl_hsv_converter_defines.svh"
module rhsl_monitor (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_tready,
   input wire logic                       rsp_tvalid,
   input wire logic                       rsp_tready,
   input wire logic [rhsl_pkg::RSP_W-1:0] rsp_tdata
);

   `RHSL_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled transfer changed")
   `RHSL_ASSERT(a_hue_range, clock, reset, rsp_tvalid |-> rsp_tdata[8:0] <= 9'd360, "hue above 360")
   `RHSL_ASSERT(a_pct_range, clock, reset, rsp_tvalid |-> rsp_tdata[15:9] <= 7'd100 && rsp_tdata[22:16] <= 7'd100 && !rsp_tdata[23], "percent field out of range")
   `RHSL_ASSERT(a_empty_ready, clock, reset, !rsp_tvalid |-> req_tready, "input blocked with empty output")
   `RHSL_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

bind rgb_to_hsl_hsv_converter rhsl_monitor u_rhsl_monitor (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

@@ tb/sv/rgb_to_hsl_hsv_converter_checker.sv @@
// Checker for the RGB to HSL/HSV converter: watches the csr, pixel and result channels,
// predicts each result from the accepted pixel and the current mode, and compares.
// Depends on rhsl_pkg for the channel widths.
module rgb_to_hsl_hsv_converter_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic                       csr_data,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [rhsl_pkg::REQ_W-1:0] req_tdata,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [rhsl_pkg::RSP_W-1:0] rsp_tdata,
   output int                         outstanding,
   output int                         error_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // same bit order as rsp_tdata, lowest field last
   typedef struct packed {
      logic                         pad;
      logic [rhsl_pkg::LVL_W-1:0]   level;
      logic [rhsl_pkg::SAT_W-1:0]   saturation;
      logic [rhsl_pkg::HUE_W-1:0]   hue;
   } color_type;

   color_type expected_colors[$];
   logic      hsv_mode;

   function automatic int round_half_up(input int num, input int den);
      return (2 * num + den) / (2 * den);
   endfunction

   function automatic color_type convert_pixel(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b, input logic hsv);
      int        ri, gi, bi, mx, mn, d, n, den, hue, sat, lvl;
      color_type c;
      ri = r;
      gi = g;
      bi = b;
      mx = ri;
      mn = ri;
      if (gi > mx) mx = gi;
      if (bi > mx) mx = bi;
      if (gi < mn) mn = gi;
      if (bi < mn) mn = bi;
      d = mx - mn;
      hue = 0;
      sat = 0;
      if (d != 0) begin
         // red wins ties over green, green over blue
         if (mx == ri) begin
            n = (gi >= bi) ? 60 * (gi - bi) : 360 * d - 60 * (bi - gi);
         end else if (mx == gi) begin
            n = 120 * d + 60 * (bi - ri);
         end else begin
            n = 240 * d + 60 * (ri - gi);
         end
         hue = round_half_up(n, d);
         if (hsv) begin
            sat = round_half_up(100 * d, mx);
         end else begin
            den = (mx + mn < 255) ? mx + mn : 510 - mx - mn;
            sat = round_half_up(100 * d, den);
         end
      end
      lvl = hsv ? round_half_up(100 * mx, 255) : round_half_up(100 * (mx + mn), 510);
      c.pad = 1'b0;
      c.hue = hue[rhsl_pkg::HUE_W-1:0];
      c.saturation = sat[rhsl_pkg::SAT_W-1:0];
      c.level = lvl[rhsl_pkg::LVL_W-1:0];
      return c;
   endfunction

   always @(posedge clock) begin : monitor
      color_type want, got;
      if (reset) begin
         expected_colors.delete();
         hsv_mode = 1'b0;
         error_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = color_type'(rsp_tdata);
            if (expected_colors.size() == 0) begin
               $display("%0t: result transfer %h with nothing expected", $time, rsp_tdata);
               error_count++;
            end else begin
               want = expected_colors.pop_front();
               if (got.hue !== want.hue || got.saturation !== want.saturation ||
                   got.level !== want.level || got.pad !== want.pad) begin
                  $display("%0t: expected hue %0d sat %0d level %0d pad %b, got hue %0d sat %0d level %0d pad %b",
                           $time, want.hue, want.saturation, want.level, want.pad,
                           got.hue, got.saturation, got.level, got.pad);
                  error_count++;
               end
            end
         end
         if (csr_valid && csr_ready)
            hsv_mode = csr_data;
         if (req_tvalid && req_tready)
            expected_colors.push_back(convert_pixel(req_tdata[7:0], req_tdata[15:8],
                                                    req_tdata[23:16], hsv_mode));
      end
      outstanding <= expected_colors.size();
   end

endmodule

@@ tb/sv/rgb_to_hsl_hsv_converter_tb.sv @@
// Testbench top for the RGB to HSL/HSV converter: clock, reset, pixel and csr stimulus,
// random backpressure and the final verdict.
// Depends on rhsl_pkg, rgb_to_hsl_hsv_converter and rgb_to_hsl_hsv_converter_checker.
module rgb_to_hsl_hsv_converter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rhsl_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int HOLD_CYCLES   = 80;
   localparam int SETTLE_CYCLES = 30;
   localparam int PHASE_ITEMS   = 228;
   localparam int PHASES        = 8;

   typedef enum logic {
      MODE_HSL = 1'b0,
      MODE_HSV = 1'b1
   } mode_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic             csr_data = 1'b0;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   int outstanding;
   int error_count;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   rgb_to_hsl_hsv_converter u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   rgb_to_hsl_hsv_converter_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .outstanding (outstanding),
      .error_count (error_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // result side: random stalls plus a single long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
      end else if (hold_requests != hold_seen) begin
         hold_seen <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("rgb_to_hsl_hsv_converter_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {b, g, r};
      do @(posedge clock); while (!req_tready);
   endtask

   // stop offering and wait until every expected result has been seen
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_mode(input mode_type m);
      csr_valid <= 1'b1;
      csr_data <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic send_corner_pixels();
      send_pixel(8'd0,   8'd0,   8'd0);     // black
      send_pixel(8'd255, 8'd255, 8'd255);   // white
      send_pixel(8'd128, 8'd128, 8'd128);   // grey
      send_pixel(8'd1,   8'd1,   8'd1);
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);     // red/green tie
      send_pixel(8'd0,   8'd255, 8'd255);   // green/blue tie
      send_pixel(8'd255, 8'd0,   8'd255);   // red/blue tie
      send_pixel(8'd255, 8'd0,   8'd1);     // hue rounds up to 360
      send_pixel(8'd255, 8'd1,   8'd0);
      send_pixel(8'd40,  8'd200, 8'd10);    // green max, blue below red
      send_pixel(8'd10,  8'd200, 8'd40);    // green max, blue above red
      send_pixel(8'd90,  8'd30,  8'd220);   // blue max
      send_pixel(8'd100, 8'd50,  8'd0);     // max+min below 255
      send_pixel(8'd254, 8'd0,   8'd100);   // max+min just below 255
      send_pixel(8'd200, 8'd55,  8'd120);   // max+min equal to 255
      send_pixel(8'd1,   8'd0,   8'd0);
      send_pixel(8'd0,   8'd0,   8'd1);
      send_pixel(8'd255, 8'd254, 8'd254);
      send_pixel(8'd170, 8'd85,  8'd255);
   endtask

   task automatic send_random_pixel();
      logic [7:0] r, g, b;
      int         sum;
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
      case ($urandom_range(7))
         0: begin
            g = r;
            b = r;
         end
         1: g = r;
         2: b = g;
         3: b = r;
         4: begin
            // lightness saturation switches divisor around max+min = 255
            sum = $urandom_range(256, 254);
            r = 8'($urandom_range(254, 128));
            g = 8'(sum - r);
            b = 8'($urandom_range(r, g));
            case ($urandom_range(2))
               1: {r, g, b} = {g, b, r};
               2: {r, g, b} = {b, r, g};
               default: ;
            endcase
         end
         5: begin
            r = $urandom_range(1) ? 8'hFF : 8'h00;
            g = $urandom_range(1) ? 8'hFF : 8'h01;
            b = $urandom_range(1) ? 8'hFE : 8'h00;
         end
         default: ;
      endcase
      send_pixel(r, g, b);
   endtask

   initial begin : stimulus
      int       ph, k;
      mode_type m;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_corner_pixels();
      drain_results();
      write_mode(MODE_HSV);
      send_corner_pixels();
      drain_results();

      for (ph = 0; ph < PHASES; ph++) begin
         m = (ph % 2 == 0) ? MODE_HSL : MODE_HSV;
         write_mode(m);
         case (ph / 2)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct <= 0;
            end
            1: begin
               send_idle_pct = 85;
               rsp_stall_pct <= 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct <= 85;
            end
            default: begin
               send_idle_pct = 12;
               rsp_stall_pct <= 12;
            end
         endcase
         // fill the pipeline against a blocked result channel
         if (ph == 0)
            hold_requests <= hold_requests + 1;
         for (k = 0; k < PHASE_ITEMS; k++) begin
            send_random_pixel();
            if (ph == 5 && k == PHASE_ITEMS / 2)
               drain_results();
         end
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && outstanding == 0) begin
         $display("rgb_to_hsl_hsv_converter_tb: clean");
      end else begin
         $display("rgb_to_hsl_hsv_converter_tb: errors");
      end
      $finish;
   end

endmodule

@@ rgb_to_hsl_hsv_converter.f @@
+incdir+hdl
hdl/rhsl_pkg.sv
hdl/rhsl_divider.sv
hdl/rgb_to_hsl_hsv_converter.sv
hdl/rhsl_monitor.sv
tb/sv/rgb_to_hsl_hsv_converter_checker.sv
tb/sv/rgb_to_hsl_hsv_converter_tb.sv
